// ===== src/c2d_pkg.sv =====
`default_nettype none
package c2d_pkg;
  localparam int MAX_IN_CHANNELS  = 16;
  localparam int MAX_OUT_CHANNELS = 16;
  localparam int MAX_KERNEL       = 7;
  localparam int MAX_IMAGE        = 64;

  localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int SDEPTH = MAX_IN_CHANNELS * MAX_IMAGE * MAX_IMAGE;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int SAW    = $clog2(SDEPTH);

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_SAMPLE  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  localparam logic [2:0] REG_KCOLS = 3'd0;
  localparam logic [2:0] REG_KROWS = 3'd1;
  localparam logic [2:0] REG_STEP  = 3'd2;
  localparam logic [2:0] REG_ICH   = 3'd3;
  localparam logic [2:0] REG_OCH   = 3'd4;
  localparam logic [2:0] REG_IROWS = 3'd5;
  localparam logic [2:0] REG_ICOLS = 3'd6;

  typedef struct packed {
    logic [2:0] kc;
    logic [2:0] kr;
    logic [2:0] st;
    logic [4:0] ic;
    logic [4:0] oc;
    logic [6:0] ir;
    logic [6:0] icl;
  } cfg_t;

  typedef struct packed {
    op_t          op;
    logic [3:0]   f;
    logic [3:0]   c;
    logic [5:0]   r;
    logic [5:0]   k;
    logic [15:0]  val;
    logic [31:0]  bias;
  } cmd_t;

  function automatic logic [2:0] clamp3(input logic [2:0] v);
    clamp3 = (v == 3'd0) ? 3'd1 : v;
  endfunction

  function automatic logic [4:0] clamp5(input logic [4:0] v);
    if (v == 5'd0) clamp5 = 5'd1;
    else if (v > 5'd16) clamp5 = 5'd16;
    else clamp5 = v;
  endfunction

  function automatic logic [6:0] clamp7(input logic [6:0] v);
    if (v == 7'd0) clamp7 = 7'd1;
    else if (v > 7'd64) clamp7 = 7'd64;
    else clamp7 = v;
  endfunction
endpackage
`default_nettype wire

// ===== src/c2d_if.sv =====
`default_nettype none
interface c2d_in_if;
  import c2d_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  filter_index;
  logic [3:0]  channel_index;
  logic [5:0]  row_index;
  logic [5:0]  col_index;
  logic signed [15:0] sample_or_weight;
  logic signed [31:0] bias_word;
  modport source (output valid, operation, filter_index, channel_index, row_index,
                  col_index, sample_or_weight, bias_word, input ready);
  modport sink (input valid, operation, filter_index, channel_index, row_index,
                col_index, sample_or_weight, bias_word, output ready);
endinterface

interface c2d_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        saturated;
  logic        bad_index;
  modport source (output valid, result_value, saturated, bad_index, input ready);
  modport sink (input valid, result_value, saturated, bad_index, output ready);
endinterface
`default_nettype wire

// ===== src/c2d_front.sv =====
`default_nettype none
module c2d_front
  import c2d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  c2d_in_if.sink    in_ch,
  output cmd_t      q_data,
  output logic      q_valid,
  input  wire logic q_pop
);
  localparam int QD = 2;
  cmd_t       q_r [QD];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'(QD));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].op   <= op_t'(in_ch.operation);
      q_r[wp_r].f    <= in_ch.filter_index;
      q_r[wp_r].c    <= in_ch.channel_index;
      q_r[wp_r].r    <= in_ch.row_index;
      q_r[wp_r].k    <= in_ch.col_index;
      q_r[wp_r].val  <= in_ch.sample_or_weight;
      q_r[wp_r].bias <= in_ch.bias_word;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QD))
    else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QD)) |-> !in_ch.ready) else $error("ready while full");
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_valid) |=> (cnt_r == 2'd1)) else $error("push lost");
endmodule
`default_nettype wire

// ===== src/c2d_back.sv =====
`default_nettype none
module c2d_back
  import c2d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  cmd_t      q_data,
  input  wire logic q_valid,
  output logic      q_pop,
  c2d_out_if.source out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_BIAS, S_SAT, S_OUT} st_t;

  logic [15:0] wmem [WDEPTH];
  logic [15:0] smem [SDEPTH];
  logic [31:0] bmem [MAX_OUT_CHANNELS];

  st_t         st_r;
  cmd_t        cmd_r;
  logic [2:0]  kc, kr, stp;
  logic [4:0]  ic, oc;
  logic [6:0]  orows, ocols;
  logic [3:0]  ch_r;
  logic [2:0]  y_r, x_r;
  logic [7:0]  sy, sx;
  logic        rd_v_r, rd_in_r, mul_v_r;
  logic [15:0] wq_r, sq_r;
  logic signed [31:0] prod_r;
  logic signed [40:0] acc_r;
  logic signed [31:0] bias_r;
  logic [31:0] res_r;
  logic        sat_r, bad_r;
  logic        last_tap;
  logic [WAW-1:0] waddr;
  logic [SAW-1:0] saddr;

  // quotient by reciprocal multiply, exact for d below 128
  function automatic logic [6:0] osz(input logic [6:0] img, input logic [2:0] k,
                                     input logic [2:0] s);
    logic [6:0] d;
    logic [6:0] q;
    d = img - {4'd0, k};
    case (s)
      3'd1: q = d;
      3'd2: q = d >> 1;
      3'd3: q = 7'((17'(d) * 17'd342) >> 10);
      3'd4: q = d >> 2;
      3'd5: q = 7'((17'(d) * 17'd205) >> 10);
      3'd6: q = 7'((17'(d) * 17'd171) >> 10);
      3'd7: q = 7'((17'(d) * 17'd147) >> 10);
      default: q = d;
    endcase
    osz = (img < {4'd0, k}) ? 7'd0 : q + 7'd1;
  endfunction

  assign kc  = clamp3(cfg.kc);
  assign kr  = clamp3(cfg.kr);
  assign stp = clamp3(cfg.st);
  assign ic  = clamp5(cfg.ic);
  assign oc  = clamp5(cfg.oc);
  assign orows = osz(clamp7(cfg.ir), kr, stp);
  assign ocols = osz(clamp7(cfg.icl), kc, stp);

  assign sy = 8'(cmd_r.r) * 8'(stp) + 8'(y_r);
  assign sx = 8'(cmd_r.k) * 8'(stp) + 8'(x_r);
  assign waddr = WAW'((((cmd_r.f * MAX_IN_CHANNELS + ch_r) * MAX_KERNEL + y_r)
                       * MAX_KERNEL) + x_r);
  assign saddr = {ch_r, sy[5:0], sx[5:0]};
  assign last_tap = (x_r == kc - 3'd1) && (y_r == kr - 3'd1) && (ch_r == 4'(ic - 5'd1));

  assign q_pop = q_valid && (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.result_value = res_r;
  assign out_ch.saturated = sat_r;
  assign out_ch.bad_index = bad_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.op == OP_WEIGHT && q_data.r < 6'(MAX_KERNEL) && q_data.k < 6'(MAX_KERNEL))
        wmem[WAW'((((q_data.f * MAX_IN_CHANNELS + q_data.c) * MAX_KERNEL + q_data.r)
                   * MAX_KERNEL) + q_data.k)] <= q_data.val;
      if (q_data.op == OP_SAMPLE)
        smem[{q_data.c, q_data.r, q_data.k}] <= q_data.val;
      if (q_data.op == OP_BIAS) bmem[q_data.f] <= q_data.bias;
    end
    wq_r <= wmem[waddr];
    sq_r <= smem[saddr];
    bias_r <= bmem[cmd_r.f];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= (st_r == S_RUN);
      rd_in_r <= (sy < 8'(MAX_IMAGE)) && (sx < 8'(MAX_IMAGE));
      mul_v_r <= rd_v_r;
      prod_r  <= $signed(wq_r) * (rd_in_r ? $signed(sq_r) : 16'sd0);
      if (mul_v_r && st_r != S_IDLE) acc_r <= acc_r + 41'(prod_r);
      case (st_r)
        S_IDLE: begin
          if (q_pop && q_data.op == OP_COMPUTE) begin
            cmd_r <= q_data;
            ch_r <= '0; y_r <= '0; x_r <= '0;
            acc_r <= '0;
            st_r <= S_RUN;
          end
        end
        S_RUN: begin
          if ({1'b0, cmd_r.f} >= oc || {1'b0, cmd_r.r} >= orows ||
              {1'b0, cmd_r.k} >= ocols) begin
            res_r <= '0; sat_r <= 1'b0; bad_r <= 1'b1;
            st_r <= S_OUT;
          end else if (last_tap) begin
            st_r <= S_DRAIN;
          end else if (x_r != kc - 3'd1) begin
            x_r <= x_r + 3'd1;
          end else begin
            x_r <= '0;
            if (y_r != kr - 3'd1) y_r <= y_r + 3'd1;
            else begin
              y_r <= '0;
              ch_r <= ch_r + 4'd1;
            end
          end
        end
        S_DRAIN: if (!rd_v_r && !mul_v_r) st_r <= S_BIAS;
        S_BIAS: begin
          acc_r <= acc_r + 41'(bias_r);
          st_r <= S_SAT;
        end
        S_SAT: begin
          bad_r <= 1'b0;
          if (acc_r > 41'sh7FFFFFFF) begin
            res_r <= 32'h7FFFFFFF; sat_r <= 1'b1;
          end else if (acc_r < -41'sh80000000) begin
            res_r <= 32'h80000000; sat_r <= 1'b1;
          end else begin
            res_r <= acc_r[31:0]; sat_r <= 1'b0;
          end
          st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(res_r)) else $error("result moved");
  a_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_pop) else $error("pop while busy");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_BIAS) |-> (!mul_v_r && !rd_v_r)) else $error("bias before drain");
endmodule
`default_nettype wire

// ===== src/conv2d_forward_engine.sv =====
`default_nettype none
// channel | dir | handshake      | payload
// in_     | in  | valid/ready    | operation, indices, sample_or_weight, bias_word
// out_    | out | valid/ready    | result_value, saturated, bad_index
// cfg_    | in  | APB, pready=1  | 7 registers at 4*i
// Load transactions retire when the back pops them. A compute reads the stores
// once per tap (ic*kr*kc taps), then drains, adds bias, clips and outputs; a bad
// position goes to output with bad_index. A two-entry queue parts front and back.
// rst_n is synchronous; stores are not cleared. A stalled result blocks the back.
module conv2d_forward_engine
  import c2d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  c2d_in_if.sink           in_ch,
  c2d_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  cfg_t cfg_r;
  cmd_t q_data;
  logic q_valid, q_pop;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{kc: 3'd3, kr: 3'd3, st: 3'd1, ic: 5'd1, oc: 5'd1, ir: 7'd64, icl: 7'd64};
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (ridx)
        REG_KCOLS: cfg_r.kc  <= cfg_pwdata[2:0];
        REG_KROWS: cfg_r.kr  <= cfg_pwdata[2:0];
        REG_STEP:  cfg_r.st  <= cfg_pwdata[2:0];
        REG_ICH:   cfg_r.ic  <= cfg_pwdata[4:0];
        REG_OCH:   cfg_r.oc  <= cfg_pwdata[4:0];
        REG_IROWS: cfg_r.ir  <= cfg_pwdata[6:0];
        REG_ICOLS: cfg_r.icl <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_KCOLS: cfg_prdata = {29'd0, cfg_r.kc};
      REG_KROWS: cfg_prdata = {29'd0, cfg_r.kr};
      REG_STEP:  cfg_prdata = {29'd0, cfg_r.st};
      REG_ICH:   cfg_prdata = {27'd0, cfg_r.ic};
      REG_OCH:   cfg_prdata = {27'd0, cfg_r.oc};
      REG_IROWS: cfg_prdata = {25'd0, cfg_r.ir};
      REG_ICOLS: cfg_prdata = {25'd0, cfg_r.icl};
      default:   cfg_prdata = '0;
    endcase
  end

  c2d_front u_front (.clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop);
  c2d_back u_back (.clk, .rst_n, .cfg(cfg_r), .q_data, .q_valid, .q_pop, .out_ch);
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import c2d_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
    logic               bad;
  } conv_res_t;

  typedef struct {
    cmd_t      cmd;
    bit        typed;
    conv_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  c2d_in_if in_ch();
  c2d_out_if out_ch();

  conv2d_forward_engine dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0] weight_mem [WDEPTH];
  bit          weight_set [WDEPTH];
  logic [15:0] sample_mem [SDEPTH];
  bit          sample_set [SDEPTH];
  logic [31:0] bias_mem [MAX_OUT_CHANNELS];
  bit          bias_set [MAX_OUT_CHANNELS];
  logic [6:0]  regs [7];

  conv_res_t pending_results[$];
  int errors = 0, computes_seen = 0, bad_seen = 0, sat_seen = 0, phases_run = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit rx_hold_req = 1'b0;
  int unsigned cycles = 0;

  function automatic int widx(int f, int c, int r, int k);
    return ((f * MAX_IN_CHANNELS + c) * MAX_KERNEL + r) * MAX_KERNEL + k;
  endfunction

  function automatic int sidx(int c, int r, int k);
    return (c * MAX_IMAGE + r) * MAX_IMAGE + k;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int out_dim(int img, int k, int s);
    return (img < k) ? 0 : (img - k) / s + 1;
  endfunction

  // effective geometry: kc, kr, st, ic, oc, orows, ocols
  function automatic void geometry(output int kc, output int kr, output int st,
                                   output int ic, output int oc, output int orows,
                                   output int ocols);
    kc = clip(regs[REG_KCOLS], 1, MAX_KERNEL);
    kr = clip(regs[REG_KROWS], 1, MAX_KERNEL);
    st = clip(regs[REG_STEP], 1, 7);
    ic = clip(regs[REG_ICH], 1, MAX_IN_CHANNELS);
    oc = clip(regs[REG_OCH], 1, MAX_OUT_CHANNELS);
    orows = out_dim(clip(regs[REG_IROWS], 1, MAX_IMAGE), kr, st);
    ocols = out_dim(clip(regs[REG_ICOLS], 1, MAX_IMAGE), kc, st);
  endfunction

  function automatic void store_load(cmd_t c);
    case (c.op)
      OP_WEIGHT: if (c.r < MAX_KERNEL && c.k < MAX_KERNEL) begin
        weight_mem[widx(c.f, c.c, c.r, c.k)] = c.val;
        weight_set[widx(c.f, c.c, c.r, c.k)] = 1'b1;
      end
      OP_BIAS: begin
        bias_mem[c.f] = c.bias;
        bias_set[c.f] = 1'b1;
      end
      OP_SAMPLE: begin
        sample_mem[sidx(c.c, c.r, c.k)] = c.val;
        sample_set[sidx(c.c, c.r, c.k)] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic conv_res_t conv_eval(cmd_t c);
    int kc, kr, st, ic, oc, orows, ocols, sy, sx;
    longint acc;
    conv_res_t res;
    geometry(kc, kr, st, ic, oc, orows, ocols);
    res.value = '0;
    res.sat = 1'b0;
    res.bad = 1'b0;
    if (c.f >= oc || c.r >= orows || c.k >= ocols) begin
      res.bad = 1'b1;
      return res;
    end
    acc = 0;
    for (int ch = 0; ch < ic; ch++)
      for (int y = 0; y < kr; y++)
        for (int x = 0; x < kc; x++) begin
          sy = c.r * st + y;
          sx = c.k * st + x;
          if (sy < MAX_IMAGE && sx < MAX_IMAGE)
            acc += longint'($signed(weight_mem[widx(c.f, ch, y, x)])) *
                   longint'($signed(sample_mem[sidx(ch, sy, sx)]));
        end
    acc += longint'($signed(bias_mem[c.f]));
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = acc[31:0];
    return res;
  endfunction

  // called right after a falling edge; returns right after a falling edge
  task automatic send(cmd_t c, bit typed = 1'b0, conv_res_t typed_res = '{0, 0, 0});
    while (!calm && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= c.op;
    in_ch.filter_index <= c.f;
    in_ch.channel_index <= c.c;
    in_ch.row_index <= c.r;
    in_ch.col_index <= c.k;
    in_ch.sample_or_weight <= c.val;
    in_ch.bias_word <= c.bias;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (c.op == OP_COMPUTE)
      pending_results.push_back(typed ? typed_res : conv_eval(c));
    else
      store_load(c);
    @(negedge clk);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.op = op_t'($urandom_range(3));
    c.f = $urandom;
    c.c = $urandom;
    c.r = $urandom;
    c.k = $urandom;
    c.val = $urandom;
    c.bias = $urandom;
    return c;
  endfunction

  function automatic cmd_t load_cmd(op_t op, int f, int ch, int r, int k);
    cmd_t c;
    c = rand_cmd();
    c.op = op;
    c.f = f;
    c.c = ch;
    c.r = r;
    c.k = k;
    return c;
  endfunction

  // fill every store entry a valid output position reads, then compute it
  task automatic compute_at(int f, int r, int k);
    int kc, kr, st, ic, oc, orows, ocols, sy, sx;
    cmd_t c;
    geometry(kc, kr, st, ic, oc, orows, ocols);
    if (!bias_set[f]) send(load_cmd(OP_BIAS, f, 0, 0, 0));
    for (int ch = 0; ch < ic; ch++)
      for (int y = 0; y < kr; y++)
        for (int x = 0; x < kc; x++) begin
          sy = r * st + y;
          sx = k * st + x;
          if (!weight_set[widx(f, ch, y, x)]) send(load_cmd(OP_WEIGHT, f, ch, y, x));
          if (sy < MAX_IMAGE && sx < MAX_IMAGE && !sample_set[sidx(ch, sy, sx)])
            send(load_cmd(OP_SAMPLE, 0, ch, sy, sx));
        end
    c = load_cmd(OP_COMPUTE, f, 0, r, k);
    send(c);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [6:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= {$urandom_range(1) ? 25'($urandom) : 25'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    regs[idx] = (idx <= REG_STEP) ? (v & 7'd7) : (idx <= REG_OCH) ? (v & 7'd31) : v;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    conv_res_t e;
    cycles++;
    if (cycles > 3000000) begin
      $display("%0t timeout", $time);
      $display("conv2d_forward_engine: mismatch");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transaction: %h sat %b bad %b", $time,
                 out_ch.result_value, out_ch.saturated, out_ch.bad_index);
        errors++;
      end else begin
        e = pending_results.pop_front();
        computes_seen++;
        if (e.bad) bad_seen++;
        if (e.sat) sat_seen++;
        if (out_ch.result_value !== e.value || out_ch.saturated !== e.sat ||
            out_ch.bad_index !== e.bad) begin
          $display("%0t expected %h sat %b bad %b, actual %h sat %b bad %b", $time,
                   e.value, e.sat, e.bad, out_ch.result_value, out_ch.saturated,
                   out_ch.bad_index);
          errors++;
        end
      end
    end
  end

  int phase_cfg [8][7] = '{
    '{1, 1, 1, 1, 1, 4, 4},
    '{7, 7, 7, 1, 16, 64, 64},
    '{0, 0, 0, 0, 0, 0, 0},
    '{3, 1, 2, 31, 20, 127, 100},
    '{5, 4, 3, 2, 3, 10, 12},
    '{7, 7, 1, 16, 16, 5, 9},
    '{2, 3, 1, 2, 2, 8, 8},
    '{4, 1, 5, 3, 16, 64, 33}
  };
  int phase_items [8] = '{40, 40, 40, 40, 60, 50, 130, 90};

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t row;
    cmd_t rc;
    int kc, kr, st, ic, oc, orows, ocols, pick, stop;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.filter_index = '0;
    in_ch.channel_index = '0;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.sample_or_weight = '0;
    in_ch.bias_word = '0;
    regs = '{3, 3, 1, 1, 1, 64, 64};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry 3x3, one channel: full-scale window saturates negative
    row.typed = 1'b0;
    row.res = '{0, 0, 0};
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) begin
        row.cmd = load_cmd(OP_WEIGHT, 0, 0, y, x);
        row.cmd.val = 16'h8000;
        dir_rows.push_back(row);
        row.cmd = load_cmd(OP_SAMPLE, 0, 0, y, x);
        row.cmd.val = 16'h7fff;
        dir_rows.push_back(row);
      end
    row.cmd = load_cmd(OP_BIAS, 0, 0, 0, 0);
    row.cmd.bias = 32'h8000_0000;
    dir_rows.push_back(row);
    row.cmd = load_cmd(OP_COMPUTE, 0, 0, 0, 0);
    row.typed = 1'b1;
    row.res = '{32'sh8000_0000, 1'b1, 1'b0};
    dir_rows.push_back(row);
    row.cmd = load_cmd(OP_COMPUTE, 15, 0, 0, 0);
    row.res = '{0, 1'b0, 1'b1};
    dir_rows.push_back(row);
    row.cmd = load_cmd(OP_COMPUTE, 0, 0, 62, 0);
    dir_rows.push_back(row);
    row.typed = 1'b0;
    row.cmd = load_cmd(OP_WEIGHT, 0, 0, 7, 63);
    dir_rows.push_back(row);
    row.cmd = load_cmd(OP_BIAS, 0, 0, 0, 0);
    row.cmd.bias = 32'h7fff_ffff;
    dir_rows.push_back(row);
    row.cmd = load_cmd(OP_COMPUTE, 0, 0, 0, 0);
    dir_rows.push_back(row);
    foreach (dir_rows[i]) send(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
    drain();

    for (int p = 0; p < 8; p++) begin
      for (int i = 0; i < 7; i++) cfg_write(3'(i), 7'(phase_cfg[p][i]));
      @(negedge clk);
      phases_run++;
      calm = (p == 6);
      if (p == 4) rx_hold_req = 1'b1;
      geometry(kc, kr, st, ic, oc, orows, ocols);
      stop = items_sent + phase_items[p];
      while (items_sent < stop) begin
        pick = $urandom_range(99);
        if (pick < 55 && orows > 0 && ocols > 0)
          compute_at($urandom_range(oc - 1), $urandom_range(orows - 1),
                     $urandom_range(ocols - 1));
        else if (pick < 70) begin
          if (oc < 16)
            send(load_cmd(OP_COMPUTE, $urandom_range(oc, 15), 0, $urandom, $urandom));
          else
            send(load_cmd(OP_COMPUTE, $urandom, 0, $urandom_range(orows, 63), $urandom));
        end else if (pick < 75)
          send(load_cmd(OP_COMPUTE, $urandom_range(oc - 1), 0,
                        $urandom_range(orows, 63), $urandom));
        else begin
          rc = rand_cmd();
          if (rc.op == OP_COMPUTE) rc.op = OP_WEIGHT;
          send(rc);
        end
      end
      drain();
    end
    calm = 1'b0;

    $display("ran %0d transactions over %0d register settings", items_sent, phases_run + 1);
    $display("checked %0d results: %0d out-of-range positions, %0d clipped sums",
             computes_seen, bad_seen, sat_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("conv2d_forward_engine: match");
    end else begin
      $display("conv2d_forward_engine: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/c2d_pkg.sv
src/c2d_if.sv
src/c2d_front.sv
src/c2d_back.sv
src/conv2d_forward_engine.sv
test/tb_top.sv
